// ===== rtl/acr_pkg.sv =====
package acr_pkg;

  localparam int NUM_CH = 6;
  localparam int CNT_W = 3;
  localparam int CFG_IDX_W = 1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_IN_CH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_CH = 1'b1;

  localparam logic [CNT_W-1:0] CNT_RESET = 3'd2;
  localparam logic [CNT_W-1:0] CNT_MIN   = 3'd1;
  localparam logic [CNT_W-1:0] CNT_MAX   = 3'd6;

  // rounding divisor of one output lane
  typedef enum logic [2:0] {
    DIV_1,
    DIV_2,
    DIV_3,
    DIV_4,
    DIV_5,
    DIV_6,
    DIV_8
  } acr_div_t;

  // long-division stages, eight quotient bits each, over a (w+2)-bit dividend
  function automatic int div_stages(int w);
    return (w + 9) >> 3;
  endfunction

  // power-of-two part of the divisor
  function automatic logic [1:0] div_shift(acr_div_t d);
    case (d)
      DIV_2, DIV_6: return 2'd1;
      DIV_4:        return 2'd2;
      DIV_8:        return 2'd3;
      default:      return 2'd0;
    endcase
  endfunction

  // odd part of the divisor
  function automatic logic [2:0] div_odd(acr_div_t d);
    case (d)
      DIV_3, DIV_6: return 3'd3;
      DIV_5:        return 3'd5;
      default:      return 3'd1;
    endcase
  endfunction

  // half the divisor, added to the magnitude for round to nearest
  function automatic logic [2:0] div_bias(acr_div_t d);
    case (d)
      DIV_2, DIV_3: return 3'd1;
      DIV_4, DIV_5: return 3'd2;
      DIV_6:        return 3'd3;
      DIV_8:        return 3'd4;
      default:      return 3'd0;
    endcase
  endfunction

  // zero counts as one channel, seven as six
  function automatic logic [CNT_W-1:0] eff_count(logic [CNT_W-1:0] r);
    if (r == '0) begin
      return CNT_MIN;
    end
    if (r > CNT_MAX) begin
      return CNT_MAX;
    end
    return r;
  endfunction

endpackage

// ===== rtl/acr_if.sv =====
interface acr_in_if #(parameter int W = 16);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] in_ch1;
  logic signed [W-1:0] in_ch2;
  logic signed [W-1:0] in_ch3;
  logic signed [W-1:0] in_ch4;
  logic signed [W-1:0] in_ch5;
  logic signed [W-1:0] in_ch6;

  modport source (
    output valid, in_ch1, in_ch2, in_ch3, in_ch4, in_ch5, in_ch6,
    input  ready
  );
  modport sink (
    input  valid, in_ch1, in_ch2, in_ch3, in_ch4, in_ch5, in_ch6,
    output ready
  );
endinterface

interface acr_out_if #(parameter int W = 16);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] out_ch1;
  logic signed [W-1:0] out_ch2;
  logic signed [W-1:0] out_ch3;
  logic signed [W-1:0] out_ch4;
  logic signed [W-1:0] out_ch5;
  logic signed [W-1:0] out_ch6;

  modport source (
    output valid, out_ch1, out_ch2, out_ch3, out_ch4, out_ch5, out_ch6,
    input  ready
  );
  modport sink (
    input  valid, out_ch1, out_ch2, out_ch3, out_ch4, out_ch5, out_ch6,
    output ready
  );
endinterface

// ===== rtl/acr_mix.sv =====
module acr_mix import acr_pkg::*; #(
  parameter int W = 16
) (
  input  logic                             clk,
  input  logic                             load,
  input  logic [CNT_W-1:0]                 ic,
  input  logic [CNT_W-1:0]                 oc,
  input  logic [NUM_CH-1:0][W-1:0]         smp,
  output logic [NUM_CH-1:0][W+3:0]         num_r,
  output acr_div_t [NUM_CH-1:0]            dc_r,
  output logic [NUM_CH-1:0][W-1:0]         add_r,
  output logic [NUM_CH-1:0]                used_r
);

  localparam int NW = W + 4;

  logic signed [NW-1:0] xe [NUM_CH];
  logic signed [NW-1:0] a, b, c, d, e, f;
  logic signed [NW-1:0] pn, qn, m2, s3, s4, s5, s6;
  logic signed [NW-1:0] l3, r3, ac, bd, l5, r5, l8, r8, ad, ce;
  logic [W-1:0]         fw;

  logic [NUM_CH-1:0][NW-1:0] num_nxt;
  acr_div_t [NUM_CH-1:0]     dc_nxt;
  logic [NUM_CH-1:0][W-1:0]  add_nxt;
  logic [NUM_CH-1:0]         used_nxt;

  // channels beyond the input count read as zero
  for (genvar i = 0; i < NUM_CH; i++) begin : g_ch
    assign xe[i]       = (CNT_W'(i) < ic) ? NW'($signed(smp[i])) : '0;
    assign used_nxt[i] = (CNT_W'(i) < oc);
  end

  assign a  = xe[0];
  assign b  = xe[1];
  assign c  = xe[2];
  assign d  = xe[3];
  assign e  = xe[4];
  assign f  = xe[5];
  assign fw = f[W-1:0];

  // shared numerators
  assign pn = (a <<< 2) + a - b;
  assign qn = (b <<< 2) + b - a;
  assign m2 = a + b;
  assign s3 = m2 + c;
  assign s4 = s3 + d;
  assign s5 = s4 + e;
  assign s6 = s5 + f;
  assign l3 = (a <<< 1) + b;
  assign r3 = b + (c <<< 1);
  assign ac = a + c;
  assign bd = b + d;
  assign l5 = l3 + (d <<< 1);
  assign r5 = r3 + (e <<< 1);
  assign l8 = (ac <<< 2) + ac - bd;
  assign r8 = (bd <<< 2) + bd - ac;
  assign ad = a + d;
  assign ce = c + e;

  always_comb begin
    num_nxt = '0;
    dc_nxt  = {NUM_CH{DIV_1}};
    add_nxt = '0;
    if (ic == oc) begin
      num_nxt = {f, e, d, c, b, a};
    end else if (oc == CNT_MIN) begin
      // mono: rounded average over the full sum
      num_nxt[0] = s6;
      case (ic)
        3'd2:    dc_nxt[0] = DIV_2;
        3'd3:    dc_nxt[0] = DIV_3;
        3'd4:    dc_nxt[0] = DIV_4;
        3'd5:    dc_nxt[0] = DIV_5;
        default: dc_nxt[0] = DIV_6;
      endcase
    end else if (ic == CNT_MIN) begin
      num_nxt = {a, a, a, a, a, a};
    end else begin
      case (oc)
        3'd2: begin
          if (ic == 3'd3) begin
            num_nxt[1:0] = {r3, l3};
            dc_nxt[1:0]  = {DIV_3, DIV_3};
          end else if (ic == 3'd4) begin
            num_nxt[1:0] = {bd, ac};
            dc_nxt[1:0]  = {DIV_2, DIV_2};
          end else begin
            num_nxt[1:0] = {r5, l5};
            dc_nxt[1:0]  = {DIV_5, DIV_5};
            add_nxt[1:0] = {fw, fw};
          end
        end
        3'd3: begin
          if (ic == 3'd2) begin
            num_nxt[2:0] = {qn, m2, pn};
            dc_nxt[2:0]  = {DIV_4, DIV_2, DIV_4};
          end else if (ic == 3'd4) begin
            num_nxt[2:0] = {r8, s4, l8};
            dc_nxt[2:0]  = {DIV_8, DIV_4, DIV_8};
          end else begin
            num_nxt[2:0] = {ce, b, ad};
            dc_nxt[2:0]  = {DIV_2, DIV_1, DIV_2};
            add_nxt[2:0] = {fw, fw, fw};
          end
        end
        3'd4: begin
          if (ic == 3'd2) begin
            num_nxt[3:0] = {b, a, b, a};
          end else if (ic == 3'd3) begin
            num_nxt[3:0] = {r3, l3, r3, l3};
            dc_nxt[3:0]  = {DIV_3, DIV_3, DIV_3, DIV_3};
          end else begin
            num_nxt[3:0] = {e, d, r3, l3};
            dc_nxt[3:0]  = {DIV_1, DIV_1, DIV_3, DIV_3};
            add_nxt[3:0] = {fw, fw, fw, fw};
          end
        end
        3'd5: begin
          if (ic == 3'd2) begin
            num_nxt[4:0] = {qn, pn, qn, m2, pn};
            dc_nxt[4:0]  = {DIV_4, DIV_4, DIV_4, DIV_2, DIV_4};
          end else if (ic == 3'd3) begin
            num_nxt[4:0] = {c, a, c, b, a};
          end else if (ic == 3'd4) begin
            num_nxt[4:0] = {qn, pn, qn, s4, pn};
            dc_nxt[4:0]  = {DIV_4, DIV_4, DIV_4, DIV_4, DIV_4};
          end else begin
            num_nxt[4:0] = {e, d, c, b, a};
            add_nxt[4:0] = {fw, fw, fw, fw, fw};
          end
        end
        default: begin
          if (ic == 3'd2) begin
            num_nxt = {m2, qn, pn, qn, m2, pn};
            dc_nxt  = {DIV_2, DIV_4, DIV_4, DIV_4, DIV_2, DIV_4};
          end else if (ic == 3'd3) begin
            num_nxt = {s3, c, a, c, b, a};
            dc_nxt  = {DIV_3, DIV_1, DIV_1, DIV_1, DIV_1, DIV_1};
          end else if (ic == 3'd4) begin
            num_nxt = {s4, qn, pn, qn, s4, pn};
            dc_nxt  = {DIV_4, DIV_4, DIV_4, DIV_4, DIV_4, DIV_4};
          end else begin
            num_nxt = {s5, e, d, c, b, a};
            dc_nxt  = {DIV_5, DIV_1, DIV_1, DIV_1, DIV_1, DIV_1};
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      num_r  <= num_nxt;
      dc_r   <= dc_nxt;
      add_r  <= add_nxt;
      used_r <= used_nxt;
    end
  end

endmodule

// ===== rtl/acr_lane.sv =====
module acr_lane import acr_pkg::*; #(
  parameter int W = 16
) (
  input  logic                          clk,
  input  logic [div_stages(W)+1:0]      ld,
  input  logic [W+3:0]                  num,
  input  acr_div_t                      dc,
  input  logic [W-1:0]                  add,
  input  logic                          used,
  output logic [W-1:0]                  y_r
);

  localparam int NW = W + 4;
  localparam int MW = W + 2;
  localparam int SW = W + 3;
  localparam int ND = div_stages(W);

  localparam logic signed [SW-1:0] SAT_HI = {{(SW-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic signed [SW-1:0] SAT_LO = {{(SW-W+1){1'b1}}, {(W-1){1'b0}}};

  // per-stage payload, index 0 is the rounding prep stage
  logic [MW-1:0] xq_r   [ND+1];
  logic [2:0]    rem_r  [ND+1];
  logic [2:0]    dv_r   [ND+1];
  logic          sgn_r  [ND+1];
  logic [W-1:0]  add_r  [ND+1];
  logic          used_r [ND+1];

  // prep: magnitude plus half the divisor, then the power-of-two shift
  logic [NW-1:0] neg;
  logic [NW-2:0] mag;
  logic [NW-2:0] biased;
  logic [NW-2:0] shifted;

  assign neg     = -num;
  assign mag     = num[NW-1] ? neg[NW-2:0] : num[NW-2:0];
  assign biased  = mag + (NW-1)'(div_bias(dc));
  assign shifted = biased >> div_shift(dc);

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      xq_r[0]   <= shifted[MW-1:0];
      rem_r[0]  <= '0;
      dv_r[0]   <= div_odd(dc);
      sgn_r[0]  <= num[NW-1];
      add_r[0]  <= add;
      used_r[0] <= used;
    end
  end

  // long division by the odd part, msb first, quotient bits overwrite dividend bits
  for (genvar j = 0; j < ND; j++) begin : g_div
    localparam int HI = MW - 1 - 8 * j;
    localparam int NB = (HI + 1 < 8) ? HI + 1 : 8;

    logic [3:0]    t  [NB];
    logic [2:0]    rc [NB+1];
    logic [NB-1:0] qb;
    logic [MW-1:0] x_nxt;

    assign rc[0] = rem_r[j];

    for (genvar s = 0; s < NB; s++) begin : g_bit
      assign t[s]          = {rc[s], xq_r[j][HI-s]};
      assign qb[NB-1-s]    = (t[s] >= {1'b0, dv_r[j]});
      assign rc[s+1]       = qb[NB-1-s] ? 3'(t[s] - {1'b0, dv_r[j]}) : t[s][2:0];
    end

    always_comb begin
      x_nxt             = xq_r[j];
      x_nxt[HI -: NB]   = qb;
    end

    always_ff @(posedge clk) begin
      if (ld[j+1]) begin
        xq_r[j+1]   <= x_nxt;
        rem_r[j+1]  <= rc[NB];
        dv_r[j+1]   <= dv_r[j];
        sgn_r[j+1]  <= sgn_r[j];
        add_r[j+1]  <= add_r[j];
        used_r[j+1] <= used_r[j];
      end
    end
  end

  // restore sign, add the late term, saturate
  logic signed [SW-1:0] qs;
  logic signed [SW-1:0] val;
  logic signed [SW-1:0] sum;
  logic [W-1:0]         y_nxt;

  assign qs  = $signed({1'b0, xq_r[ND]});
  assign val = sgn_r[ND] ? -qs : qs;
  assign sum = val + SW'($signed(add_r[ND]));

  always_comb begin
    if (!used_r[ND]) begin
      y_nxt = '0;
    end else if (sum > SAT_HI) begin
      y_nxt = SAT_HI[W-1:0];
    end else if (sum < SAT_LO) begin
      y_nxt = SAT_LO[W-1:0];
    end else begin
      y_nxt = sum[W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ld[ND+1]) begin
      y_r <= y_nxt;
    end
  end

endmodule

// ===== rtl/audio_channel_remix_core.sv =====
// pipeline: a result passes the registered mix stage, rounding prep stage, div_stages
//   long-division stages and saturation/output stage after its input transaction
// throughput: one frame per cycle unless the output stalls; the long-division pipeline
//   retires eight quotient bits per stage, and every unstalled stage takes a new frame each cycle
// reset: rst_n is synchronous, active low; it empties the pipeline and sets
//   both channel counts to 2
module audio_channel_remix_core import acr_pkg::*; #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  acr_in_if.sink               in_bus,
  acr_out_if.source            out_bus,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [CNT_W-1:0]     cfg_data
);

  localparam int NDIV  = div_stages(SAMPLE_BITS);
  // mix stage, rounding prep, division stages, saturation/output stage
  localparam int DEPTH = NDIV + 3;
  localparam int NW    = SAMPLE_BITS + 4;

  // channel count registers
  logic [CNT_W-1:0] in_cnt_r;
  logic [CNT_W-1:0] out_cnt_r;
  logic [CNT_W-1:0] ic_eff;
  logic [CNT_W-1:0] oc_eff;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_cnt_r  <= CNT_RESET;
      out_cnt_r <= CNT_RESET;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_IN_CH:  in_cnt_r  <= cfg_data;
        REG_OUT_CH: out_cnt_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // counts must only change while idle, which the block does not enforce; the mix stage reads them directly
  assign ic_eff = eff_count(in_cnt_r);
  assign oc_eff = eff_count(out_cnt_r);

  // pipeline control: one valid bit per stage, a stage loads when it is empty
  // or its content moves on; bubbles collapse behind a stalled output
  logic [DEPTH-1:0] v_r;
  logic [DEPTH-1:0] v_nxt;
  logic [DEPTH-1:0] rdy;
  logic [DEPTH-1:0] ld;
  logic [DEPTH-1:0] src;

  assign rdy[DEPTH-1] = !v_r[DEPTH-1] || out_bus.ready;
  assign src[0]       = in_bus.valid;

  for (genvar s = 0; s < DEPTH - 1; s++) begin : g_ctl
    assign rdy[s]   = !v_r[s] || rdy[s+1];
    assign src[s+1] = v_r[s];
  end

  assign ld    = rdy & src;
  assign v_nxt = (rdy & src) | (~rdy & v_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign in_bus.ready  = rdy[0];
  assign out_bus.valid = v_r[DEPTH-1];

  // stage 0: channel masking and the weighting formulas
  logic [NUM_CH-1:0][SAMPLE_BITS-1:0] smp;
  logic [NUM_CH-1:0][NW-1:0]          num;
  acr_div_t [NUM_CH-1:0]              dc;
  logic [NUM_CH-1:0][SAMPLE_BITS-1:0] add;
  logic [NUM_CH-1:0]                  used;
  logic [NUM_CH-1:0][SAMPLE_BITS-1:0] y;

  assign smp = {in_bus.in_ch6, in_bus.in_ch5, in_bus.in_ch4,
                in_bus.in_ch3, in_bus.in_ch2, in_bus.in_ch1};

  acr_mix #(.W(SAMPLE_BITS)) u_mix (
    .clk    (clk),
    .load   (ld[0]),
    .ic     (ic_eff),
    .oc     (oc_eff),
    .smp    (smp),
    .num_r  (num),
    .dc_r   (dc),
    .add_r  (add),
    .used_r (used)
  );

  // later stages: one rounding divider and saturator per output channel
  for (genvar l = 0; l < NUM_CH; l++) begin : g_lane
    acr_lane #(.W(SAMPLE_BITS)) u_lane (
      .clk  (clk),
      .ld   (ld[DEPTH-1:1]),
      .num  (num[l]),
      .dc   (dc[l]),
      .add  (add[l]),
      .used (used[l]),
      .y_r  (y[l])
    );
  end

  assign out_bus.out_ch1 = y[0];
  assign out_bus.out_ch2 = y[1];
  assign out_bus.out_ch3 = y[2];
  assign out_bus.out_ch4 = y[3];
  assign out_bus.out_ch5 = y[4];
  assign out_bus.out_ch6 = y[5];

  // reset empties every stage
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> v_r == '0)
    else $error("pipeline not empty after reset");

  // an accepted transaction occupies the first stage next cycle
  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    in_bus.valid && in_bus.ready |=> v_r[0])
    else $error("accepted transaction lost at pipeline entry");

  // input backpressure only when every stage holds a frame
  a_block_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_bus.ready |-> (&v_r))
    else $error("input blocked with a bubble in the pipeline");

  // channel six is zero whenever fewer than six outputs are configured
  a_unused_ch6: assert property (@(posedge clk) disable iff (!rst_n)
    out_bus.valid && oc_eff < CNT_MAX |-> out_bus.out_ch6 == '0)
    else $error("unused output channel six not zero");

  // mono output leaves every other channel at zero
  a_mono_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_bus.valid && oc_eff == CNT_MIN |->
      out_bus.out_ch2 == '0 && out_bus.out_ch3 == '0 && out_bus.out_ch4 == '0 &&
      out_bus.out_ch5 == '0)
    else $error("mono output with nonzero extra channels");

endmodule
